// ----- rtl/ftlr_pkg.sv -----
// Shared constants for the four-track loop recorder.
package ftlr_pkg;
  localparam int unsigned CFG_W = 21;
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_WR   = 3'd1;
  localparam logic [ST_W-1:0] ST_RD   = 3'd2;
  localparam logic [ST_W-1:0] ST_DATA = 3'd3;
  localparam logic [ST_W-1:0] ST_MOD  = 3'd4;
  localparam logic [ST_W-1:0] ST_DONE = 3'd5;
endpackage

// ----- rtl/ftlr_if.sv -----
// Handshake interfaces for the input and result channels of the loop recorder.
interface ftlr_in_if #(
  parameter int unsigned TRACKS = 4,
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [TRACKS*SAMPLE_BITS-1:0] in_track;
  logic [TRACKS-1:0]             rec_gates;
  logic [TRACKS-1:0]             clear_gates;
  logic                          all_rec_gate;
  logic                          all_clear_gate;
  logic                          play_gate;
  logic                          rewind_gate;
  modport source (output valid, in_track, rec_gates, clear_gates, all_rec_gate,
                  all_clear_gate, play_gate, rewind_gate, input ready);
  modport sink (input valid, in_track, rec_gates, clear_gates, all_rec_gate,
                all_clear_gate, play_gate, rewind_gate, output ready);
endinterface

interface ftlr_out_if #(
  parameter int unsigned TRACKS = 4,
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [TRACKS*SAMPLE_BITS-1:0] out_track;
  logic [TRACKS-1:0]             rec_status;
  logic                          play_status;
  modport source (output valid, out_track, rec_status, play_status, input ready);
  modport sink (input valid, out_track, rec_status, play_status, output ready);
endinterface

// ----- rtl/ftlr_store.sv -----
// Single-port sample memory holding every track's ring, with registered read data.
module ftlr_store #(
  parameter int unsigned AW = 22,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/ftlr_mod.sv -----
// Bit-serial restoring remainder unit used to wrap a stale playhead.
module ftlr_mod #(
  parameter int unsigned W = 21
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q;
  logic [W-1:0]  den_q;
  logic [W:0]    rem_q;
  logic [W:0]    trial;

  always_comb begin
    trial = {rem_q[W-1:0], num_q[W-1]};
    if (trial >= {1'b0, den_q}) begin
      trial = trial - {1'b0, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= trial;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[W-1:0];
endmodule

// ----- rtl/four_track_loop_recorder_core.sv -----
// Four-track loop recorder: one result beat for each input beat, built around one
// single-port sample memory. An input beat takes TRACKS write slots (ST_WR),
// then the states ST_RD and ST_DATA for each track's playback read, and ST_MOD
// for each track whose playhead was left beyond a shorter take and must be
// wrapped by the serial remainder unit. The single memory port sets this
// sequence. A new input beat is taken while the previous result still
// waits in the output register. Writing, while idle, a capacity that differs
// after clamping to 1..TRACK_DEPTH empties every take and rewinds every playhead.
module four_track_loop_recorder_core #(
  parameter int unsigned TRACKS = 4,
  parameter int unsigned TRACK_DEPTH = 1048576,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ftlr_pkg::CFG_W-1:0] cfg_wdata_i,
  ftlr_in_if.sink                  in_i,
  ftlr_out_if.source               out_o
);
  import ftlr_pkg::*;

  localparam int unsigned AW   = $clog2(TRACK_DEPTH);
  localparam int unsigned CAPW = $clog2(TRACK_DEPTH + 1);
  localparam int unsigned TW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned MAW  = TW + AW;
  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned GW   = 2 * TRACKS + 4;

  logic [ST_W-1:0]   st_q;
  logic [TW-1:0]     k_q;
  logic [CAPW-1:0]   cap_q;
  logic [CAPW-1:0]   len_q [TRACKS];
  logic [CAPW-1:0]   ph_q [TRACKS];
  logic [TRACKS-1:0] rec_q;
  logic              play_q;
  logic [GW-1:0]     prev_q;
  logic [SW-1:0]     smp_q [TRACKS];
  logic [TRACKS-1:0] wen_q;
  logic [AW-1:0]     wpos_q [TRACKS];
  logic [SW-1:0]     res_q [TRACKS];
  logic              ov_q;

  logic [GW-1:0]     now;
  logic [GW-1:0]     rise;
  logic [TRACKS-1:0] rec_n;
  logic              play_n;
  logic [CAPW-1:0]   len_n [TRACKS];
  logic [CAPW-1:0]   ph_n [TRACKS];
  logic [TRACKS-1:0] wen_n;
  logic [AW-1:0]     wpos_n [TRACKS];
  logic [31:0]       cfg_v;
  logic [CAPW-1:0]   cap_c;
  logic              accept;
  logic              k_last;
  logic              mem_we;
  logic [MAW-1:0]    mem_addr;
  logic [SW-1:0]     mem_wdata;
  logic [SW-1:0]     mem_rdata;
  logic              plays;
  logic [CAPW-1:0]   np;
  logic [CAPW-1:0]   np_sub;
  logic              mod_start;
  logic              mod_done;
  logic [CAPW-1:0]   mod_rem;
  logic              out_load;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == ST_IDLE) && !cfg_we_i;
  assign k_last = (k_q == TW'(TRACKS - 1));

  always_comb begin
    cfg_v = 32'(cfg_wdata_i);
    if (cfg_v == 32'd0) begin
      cap_c = CAPW'(1);
    end else if (cfg_v > 32'(TRACK_DEPTH)) begin
      cap_c = CAPW'(TRACK_DEPTH);
    end else begin
      cap_c = CAPW'(cfg_v);
    end
  end

  always_comb begin
    now = {in_i.rewind_gate, in_i.play_gate, in_i.all_clear_gate, in_i.all_rec_gate,
           in_i.clear_gates, in_i.rec_gates};
    rise   = now & ~prev_q;
    rec_n  = rec_q;
    play_n = play_q;
    wen_n  = '0;
    for (int t = 0; t < TRACKS; t++) begin
      len_n[t]  = len_q[t];
      ph_n[t]   = ph_q[t];
      wpos_n[t] = AW'(len_q[t]);
    end
    for (int t = 0; t < TRACKS; t++) begin
      if (rise[t]) begin
        if (rec_n[t]) begin
          rec_n[t] = 1'b0;
        end else begin
          rec_n[t] = 1'b1;
          len_n[t] = '0;
        end
      end
      if (rise[TRACKS+t]) begin
        len_n[t] = '0;
        ph_n[t]  = '0;
        rec_n[t] = 1'b0;
      end
      if (rec_n[t]) begin
        wen_n[t]  = 1'b1;
        wpos_n[t] = AW'(len_n[t]);
        if (CAPW'(len_n[t] + 1'b1) >= cap_q) begin
          len_n[t] = '0;
        end else begin
          len_n[t] = CAPW'(len_n[t] + 1'b1);
        end
      end
    end
    if (rise[2*TRACKS]) begin
      if (rec_n != '0) begin
        rec_n = '0;
      end else begin
        rec_n = '1;
        for (int t = 0; t < TRACKS; t++) begin
          len_n[t] = '0;
        end
      end
    end
    if (rise[2*TRACKS+1]) begin
      rec_n = '0;
      for (int t = 0; t < TRACKS; t++) begin
        len_n[t] = '0;
        ph_n[t]  = '0;
      end
    end
    if (rise[2*TRACKS+2]) begin
      play_n = ~play_q;
    end
    if (rise[2*TRACKS+3]) begin
      for (int t = 0; t < TRACKS; t++) begin
        ph_n[t] = '0;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {k_q, AW'(ph_q[k_q])};
    mem_wdata = smp_q[k_q];
    if (st_q == ST_WR) begin
      mem_we   = wen_q[k_q];
      mem_addr = {k_q, wpos_q[k_q]};
    end
  end

  ftlr_store #(.AW(MAW), .DW(SW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign plays  = !rec_q[k_q] && play_q && (len_q[k_q] != '0);
  assign np     = CAPW'(ph_q[k_q] + 1'b1);
  assign np_sub = np - len_q[k_q];
  assign mod_start = (st_q == ST_DATA) && plays && (np >= len_q[k_q])
                     && (np_sub >= len_q[k_q]);

  ftlr_mod #(.W(CAPW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (np),
    .den_i   (len_q[k_q]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign out_load = (st_q == ST_DONE) && (!ov_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      k_q    <= '0;
      cap_q  <= CAPW'(TRACK_DEPTH);
      rec_q  <= '0;
      play_q <= 1'b0;
      prev_q <= '0;
      ov_q   <= 1'b0;
      for (int t = 0; t < TRACKS; t++) begin
        len_q[t] <= '0;
        ph_q[t]  <= '0;
      end
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (cfg_we_i) begin
            if (cap_c != cap_q) begin
              cap_q <= cap_c;
              for (int t = 0; t < TRACKS; t++) begin
                len_q[t] <= '0;
                ph_q[t]  <= '0;
              end
            end
          end else if (accept) begin
            prev_q <= now;
            rec_q  <= rec_n;
            play_q <= play_n;
            for (int t = 0; t < TRACKS; t++) begin
              len_q[t] <= len_n[t];
              ph_q[t]  <= ph_n[t];
            end
            k_q  <= '0;
            st_q <= ST_WR;
          end
        end
        ST_WR: begin
          if (k_last) begin
            k_q  <= '0;
            st_q <= ST_RD;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_RD: begin
          st_q <= ST_DATA;
        end
        ST_DATA: begin
          if (plays) begin
            if (np < len_q[k_q]) begin
              ph_q[k_q] <= np;
            end else if (np_sub < len_q[k_q]) begin
              ph_q[k_q] <= np_sub;
            end
          end
          if (mod_start) begin
            st_q <= ST_MOD;
          end else if (k_last) begin
            st_q <= ST_DONE;
          end else begin
            k_q  <= k_q + 1'b1;
            st_q <= ST_RD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            ph_q[k_q] <= mod_rem;
            if (k_last) begin
              st_q <= ST_DONE;
            end else begin
              k_q  <= k_q + 1'b1;
              st_q <= ST_RD;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !cfg_we_i) begin
      wen_q <= wen_n;
      for (int t = 0; t < TRACKS; t++) begin
        smp_q[t]  <= in_i.in_track[t*SW +: SW];
        wpos_q[t] <= wpos_n[t];
      end
    end
    if (st_q == ST_DATA) begin
      if (rec_q[k_q] || !play_q) begin
        res_q[k_q] <= smp_q[k_q];
      end else if (len_q[k_q] != '0) begin
        res_q[k_q] <= mem_rdata;
      end else begin
        res_q[k_q] <= '0;
      end
    end
    if (out_load) begin
      for (int t = 0; t < TRACKS; t++) begin
        out_o.out_track[t*SW +: SW] <= res_q[t];
      end
      out_o.rec_status  <= rec_q;
      out_o.play_status <= play_q;
    end
  end

  assign out_o.valid = ov_q;
endmodule

// ----- dv/ftlr_checker.sv -----
// Checker that predicts the loop recorder's result beats and compares them with the block.
`timescale 1ns / 100ps
module ftlr_checker #(
  parameter int unsigned TRACKS = 4,
  parameter int unsigned TRACK_DEPTH = 1048576,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ftlr_pkg::CFG_W-1:0] cfg_wdata_i,
  ftlr_in_if                         in_mon,
  ftlr_out_if                        out_mon,
  output int                         pending_o,
  output int                         errors_o
);
  typedef struct {
    logic [SAMPLE_BITS-1:0] smp [TRACKS];
    logic [TRACKS-1:0]      rec;
    logic                   play;
  } loop_result_t;

  logic [SAMPLE_BITS-1:0] ring [int unsigned];
  int unsigned            take_len [TRACKS];
  int unsigned            head [TRACKS];
  logic [TRACKS-1:0]      recording;
  logic                   playing;
  logic [2*TRACKS+3:0]    last_gates;
  int unsigned            capacity;
  loop_result_t           awaited [$];

  function automatic int unsigned clamp_cap(logic [ftlr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > TRACK_DEPTH) return TRACK_DEPTH;
    return 32'(v);
  endfunction

  function automatic void drop_track(int t);
    take_len[t] = 0;
    head[t] = 0;
    recording[t] = 1'b0;
  endfunction

  function automatic loop_result_t loop_step();
    loop_result_t r;
    logic [2*TRACKS+3:0] now, rise;
    logic [SAMPLE_BITS-1:0] s;
    int unsigned p, idx, np, key;
    now = {in_mon.rewind_gate, in_mon.play_gate, in_mon.all_clear_gate,
           in_mon.all_rec_gate, in_mon.clear_gates, in_mon.rec_gates};
    rise = now & ~last_gates;
    last_gates = now;
    for (int t = 0; t < TRACKS; t++) begin
      s = in_mon.in_track[t*SAMPLE_BITS +: SAMPLE_BITS];
      if (rise[t]) begin
        if (recording[t]) begin
          recording[t] = 1'b0;
        end else begin
          recording[t] = 1'b1;
          take_len[t] = 0;
        end
      end
      if (rise[TRACKS+t]) drop_track(t);
      if (recording[t]) begin
        p = take_len[t] % capacity;
        ring[t*TRACK_DEPTH + p] = s;
        p++;
        take_len[t] = (p >= capacity) ? 0 : p;
      end
    end
    if (rise[2*TRACKS]) begin
      if (recording != 0) begin
        recording = '0;
      end else begin
        recording = '1;
        for (int t = 0; t < TRACKS; t++) take_len[t] = 0;
      end
    end
    if (rise[2*TRACKS+1]) for (int t = 0; t < TRACKS; t++) drop_track(t);
    if (rise[2*TRACKS+2]) playing = ~playing;
    if (rise[2*TRACKS+3]) for (int t = 0; t < TRACKS; t++) head[t] = 0;
    for (int t = 0; t < TRACKS; t++) begin
      r.smp[t] = in_mon.in_track[t*SAMPLE_BITS +: SAMPLE_BITS];
      if (!recording[t] && playing) begin
        if (take_len[t] > 0) begin
          idx = head[t] % capacity;
          np = head[t] + 1;
          key = t*TRACK_DEPTH + idx;
          r.smp[t] = ring.exists(key) ? ring[key] : '0;
          if (np >= take_len[t]) np = np % take_len[t];
          head[t] = np;
        end else begin
          r.smp[t] = '0;
        end
      end
    end
    r.rec = recording;
    r.play = playing;
    return r;
  endfunction

  assign pending_o = awaited.size();

  always @(posedge clk_i or negedge rst_ni) begin
    loop_result_t e;
    int unsigned c;
    int n;
    if (!rst_ni) begin
      for (int t = 0; t < TRACKS; t++) begin
        take_len[t] = 0;
        head[t] = 0;
      end
      recording = '0;
      playing = 1'b0;
      last_gates = '0;
      capacity = clamp_cap(ftlr_pkg::CFG_W'(TRACK_DEPTH));
      errors_o <= 0;
    end else begin
      n = 0;
      if (cfg_we_i) begin
        c = clamp_cap(cfg_wdata_i);
        if (c != capacity) begin
          capacity = c;
          for (int t = 0; t < TRACKS; t++) begin
            take_len[t] = 0;
            head[t] = 0;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) awaited.insert(awaited.size(), loop_step());
      if (out_mon.valid && out_mon.ready) begin
        if (awaited.size() == 0) begin
          $error("result beat with no expectation waiting");
          n++;
        end else begin
          e = awaited.pop_front();
          for (int t = 0; t < TRACKS; t++) begin
            if (out_mon.out_track[t*SAMPLE_BITS +: SAMPLE_BITS] !== e.smp[t]) begin
              $error("out_track%0d: expected %h, got %h", t, e.smp[t],
                     out_mon.out_track[t*SAMPLE_BITS +: SAMPLE_BITS]);
              n++;
            end
          end
          if (out_mon.rec_status !== e.rec) begin
            $error("rec_status: expected %h, got %h", e.rec, out_mon.rec_status);
            n++;
          end
          if (out_mon.play_status !== e.play) begin
            $error("play_status: expected %b, got %b", e.play, out_mon.play_status);
            n++;
          end
        end
      end
      errors_o <= errors_o + n;
    end
  end
endmodule

// ----- dv/testbench.sv -----
// Top of the loop recorder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  localparam int unsigned TRACKS = 4;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned PHASES = 7;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [TRACKS*SAMPLE_BITS-1:0] smp;
    logic [TRACKS-1:0]             rec;
    logic [TRACKS-1:0]             clr;
    logic                          all_rec;
    logic                          all_clr;
    logic                          play;
    logic                          rewind;
  } gate_beat_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [ftlr_pkg::CFG_W-1:0] cfg_wdata;
  logic                       in_taken;
  int                         pending;
  int                         errors;
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         hold_req;
  int                         hold_seen = 0;
  int                         hold_left = 0;
  int unsigned                cycles = 0;
  gate_beat_t                 levels;

  ftlr_in_if  #(.TRACKS(TRACKS), .SAMPLE_BITS(SAMPLE_BITS)) in_bus ();
  ftlr_out_if #(.TRACKS(TRACKS), .SAMPLE_BITS(SAMPLE_BITS)) out_bus ();

  four_track_loop_recorder_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_i(in_bus), .out_o(out_bus)
  );

  ftlr_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_mon(in_bus), .out_mon(out_bus), .pending_o(pending), .errors_o(errors)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    in_taken <= in_bus.valid & in_bus.ready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(gate_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    {in_bus.in_track, in_bus.rec_gates, in_bus.clear_gates, in_bus.all_rec_gate,
     in_bus.all_clear_gate, in_bus.play_gate, in_bus.rewind_gate} <= b;
    do @(negedge clk_i); while (!in_taken);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic gate_beat_t next_levels();
    gate_beat_t b;
    b = levels;
    for (int t = 0; t < TRACKS; t++) b.smp[t*SAMPLE_BITS +: SAMPLE_BITS] = pick_sample();
    if ($urandom_range(9) == 0) begin
      {b.rec, b.clr, b.all_rec, b.all_clr, b.play, b.rewind} = (2*TRACKS+4)'($urandom);
    end else begin
      for (int t = 0; t < TRACKS; t++) begin
        if ($urandom_range(19) == 0) b.rec[t] = ~b.rec[t];
        if ($urandom_range(79) == 0) b.clr[t] = ~b.clr[t];
      end
      if ($urandom_range(79) == 0) b.all_rec = ~b.all_rec;
      if ($urandom_range(199) == 0) b.all_clr = ~b.all_clr;
      if ($urandom_range(24) == 0) b.play = ~b.play;
      if ($urandom_range(69) == 0) b.rewind = ~b.rewind;
    end
    return b;
  endfunction

  task automatic drain_and_write(logic [ftlr_pkg::CFG_W-1:0] value);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ftlr_pkg::CFG_W-1:0] caps [PHASES];
    gate_beat_t b;
    caps = '{16, 1, 0, 7, 2097151, 300, 3};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_req = 0;
    tx_idle_pct = 16;
    rx_idle_pct = 75;
    levels = '0;
    in_bus.valid = 1'b0;
    {in_bus.in_track, in_bus.rec_gates, in_bus.clear_gates, in_bus.all_rec_gate,
     in_bus.all_clear_gate, in_bus.play_gate, in_bus.rewind_gate} = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats: record a few samples on every track, play them back,
    // then exercise each global edge and a stale playhead after a shorter take.
    for (int i = 0; i < 22; i++) begin
      b = '0;
      for (int t = 0; t < TRACKS; t++) begin
        b.smp[t*SAMPLE_BITS +: SAMPLE_BITS] = (i % 4 == 0) ? {1'b1, 23'h0} :
          (i % 4 == 1) ? {1'b0, {23{1'b1}}} : (i % 4 == 2) ? '0 : '1;
      end
      case (i)
        0, 1, 2, 3: b.rec = 4'hf;
        4: b.play = 1'b1;
        8: b.rec = 4'h1;
        10: b.rec = 4'h1;
        11: b.rewind = 1'b1;
        12: b.clr = 4'h2;
        13: b.all_rec = 1'b1;
        15: b.all_rec = 1'b1;
        16: b.all_rec = 1'b1;
        18: b.all_clr = 1'b1;
        19: b.play = 1'b1;
        default: ;
      endcase
      send_beat(b);
    end
    levels = b;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_write(caps[ph]);
      if (ph == 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 16;
      end else if (ph == 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int i = 0; i < 190; i++) begin
        if (ph == 1 && i == 40) hold_req <= hold_req + 1;
        if (ph == 4 && i == 90) begin
          in_bus.valid <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        levels = next_levels();
        send_beat(levels);
      end
    end

    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
